[hw/rtl/lphi_pkg.sv]
`timescale 1ns / 1ps

package lphi_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16384;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int VALUE_W     = 31;
	localparam int SIZE_W      = 15;

	// occupancy memory is kept as rows of bits
	localparam int ROW_BITS  = 32;
	localparam int ROW_IDX_W = $clog2(ROW_BITS);
	localparam int ROWS      = TABLE_DEPTH / ROW_BITS;
	localparam int ROW_W     = $clog2(ROWS);

	// home slot divider: four quotient bits per cycle
	localparam int DIV_W      = VALUE_W + 1;
	localparam int DIV_DIGITS = 4;
	localparam int DIV_CNT_W  = $clog2(DIV_W / DIV_DIGITS);

	// configuration space
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_TABLE_SIZE = '0;
	localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(10007);

	typedef enum logic [1:0] {
		STATUS_HOME   = 2'd0,
		STATUS_PROBED = 2'd1,
		STATUS_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_HOLD
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_FETCH,
		B_TEST
	} back_state_t;

	// one insert job handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [SLOT_W-1:0]  home;
		logic [SIZE_W-1:0]  size;
	} job_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
		logic [CNT_W-1:0]  probes;
		logic [CNT_W-1:0]  occupancy;
	} result_t;

	// zero counts as one slot, anything past the depth as the full depth
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
		logic [SIZE_W-1:0] s;
		s = r;
		if (r == '0)
			s = SIZE_W'(1);
		else if (r > SIZE_W'(TABLE_DEPTH))
			s = SIZE_W'(TABLE_DEPTH);
		return s;
	endfunction

endpackage

[hw/rtl/lphi_front.sv]
`timescale 1ns / 1ps

module lphi_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [lphi_pkg::VALUE_W-1:0]   key,
	input  logic [lphi_pkg::SIZE_W-1:0]    size,
	input  logic                           clearing,
	output logic                           full,
	output logic                           job_valid,
	output lphi_pkg::job_t                 job,
	input  logic                           job_pop
);

	lphi_pkg::front_state_t state_q, state_nxt;

	logic [lphi_pkg::VALUE_W-1:0]   val_q;
	logic [lphi_pkg::DIV_W-1:0]     dvd_q, dvd_nxt;
	logic [lphi_pkg::SIZE_W-1:0]    rem_q, rem_nxt;
	logic [lphi_pkg::SIZE_W-1:0]    size_q;
	logic [lphi_pkg::DIV_CNT_W-1:0] div_cnt_q;

	lphi_pkg::job_t q_mem_q [2];
	logic           q_wr_q, q_rd_q;
	logic [1:0]     q_cnt_q;

	logic accept, q_push, div_done;

	// restoring division, several quotient bits per cycle; only the remainder is kept
	always_comb begin
		logic [lphi_pkg::SIZE_W:0]  r;
		logic [lphi_pkg::DIV_W-1:0] d;
		r = {1'b0, rem_q};
		d = dvd_q;
		for (int k = 0; k < lphi_pkg::DIV_DIGITS; k++) begin
			r = {r[lphi_pkg::SIZE_W-1:0], d[lphi_pkg::DIV_W-1]};
			d = {d[lphi_pkg::DIV_W-2:0], 1'b0};
			if (r >= {1'b0, size_q})
				r = r - {1'b0, size_q};
		end
		rem_nxt = r[lphi_pkg::SIZE_W-1:0];
		dvd_nxt = d;
	end

	assign full     = clearing || (state_q != lphi_pkg::F_IDLE);
	assign accept   = push && !full;
	assign div_done = (div_cnt_q == {lphi_pkg::DIV_CNT_W{1'b1}});

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lphi_pkg::F_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		q_push    = 1'b0;
		unique case (state_q)
			lphi_pkg::F_IDLE: begin
				if (accept)
					state_nxt = lphi_pkg::F_DIV;
			end
			lphi_pkg::F_DIV: begin
				if (div_done)
					state_nxt = lphi_pkg::F_HOLD;
			end
			lphi_pkg::F_HOLD: begin
				if (q_cnt_q != 2'd2) begin
					q_push    = 1'b1;
					state_nxt = lphi_pkg::F_IDLE;
				end
			end
			default: state_nxt = lphi_pkg::F_IDLE;
		endcase
	end

	// divider counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (accept)
			div_cnt_q <= '0;
		else if (state_q == lphi_pkg::F_DIV)
			div_cnt_q <= div_cnt_q + lphi_pkg::DIV_CNT_W'(1);
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= key;
			dvd_q  <= lphi_pkg::DIV_W'(key);
			rem_q  <= '0;
			size_q <= size;
		end else if (state_q == lphi_pkg::F_DIV) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	// two-word job queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			if (q_push)
				q_wr_q <= !q_wr_q;
			if (job_pop)
				q_rd_q <= !q_rd_q;
			case ({q_push, job_pop})
				2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
				2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push)
			q_mem_q[q_wr_q] <= '{value: val_q,
			                     home: rem_q[lphi_pkg::SLOT_W-1:0],
			                     size: size_q};
	end

	assign job_valid = (q_cnt_q != 2'd0);
	assign job       = q_mem_q[q_rd_q];

endmodule

[hw/rtl/lphi_back.sv]
`timescale 1ns / 1ps

module lphi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  lphi_pkg::job_t    job,
	output logic              job_pop,
	output logic              clearing,
	output logic              empty,
	input  logic              pop,
	output lphi_pkg::result_t result
);

	localparam int SW = lphi_pkg::SLOT_W;
	localparam int IW = lphi_pkg::ROW_IDX_W;

	lphi_pkg::back_state_t state_q, state_nxt;

	// occupancy rows and stored values
	logic [lphi_pkg::ROW_BITS-1:0] used_mem  [lphi_pkg::ROWS];
	logic [lphi_pkg::VALUE_W-1:0]  value_mem [lphi_pkg::TABLE_DEPTH];
	logic [lphi_pkg::ROW_BITS-1:0] row_q;

	logic [lphi_pkg::ROW_W-1:0]   clr_row_q;
	logic [SW-1:0]                pos_q, pos_nxt;
	logic [lphi_pkg::CNT_W-1:0]   passed_q, pos_inc;
	logic [lphi_pkg::SIZE_W-1:0]  size_q;
	logic [lphi_pkg::VALUE_W-1:0] value_q;
	logic [lphi_pkg::CNT_W-1:0]   used_count_q;

	lphi_pkg::result_t oq_mem_q [2];
	logic              oq_wr_q, oq_rd_q;
	logic [1:0]        oq_cnt_q;

	logic                          mem_we, mem_re, ins, step, res_push, clr_last;
	logic [lphi_pkg::ROW_W-1:0]    mem_wa, mem_ra;
	logic [lphi_pkg::ROW_BITS-1:0] mem_wd, set_mask;
	logic                          cur_bit, is_full;
	lphi_pkg::result_t             res_d;

	// probe position arithmetic
	assign cur_bit  = row_q[pos_q[IW-1:0]];
	assign set_mask = lphi_pkg::ROW_BITS'(1) << pos_q[IW-1:0];
	assign pos_inc  = {1'b0, pos_q} + lphi_pkg::CNT_W'(1);
	assign pos_nxt  = (pos_inc == size_q) ? '0 : pos_inc[SW-1:0];
	assign is_full  = (passed_q >= size_q);
	assign clr_last = (clr_row_q == lphi_pkg::ROW_W'(lphi_pkg::ROWS - 1));

	assign clearing = (state_q == lphi_pkg::B_CLEAR);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lphi_pkg::B_CLEAR;
		else
			state_q <= state_nxt;
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		job_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = clr_row_q;
		mem_wd    = '0;
		mem_re    = 1'b0;
		mem_ra    = pos_q[SW-1:IW];
		ins       = 1'b0;
		step      = 1'b0;
		res_push  = 1'b0;
		res_d     = '{slot: '0, status: lphi_pkg::STATUS_FULL,
		              probes: size_q, occupancy: used_count_q};
		unique case (state_q)
			lphi_pkg::B_CLEAR: begin
				mem_we = 1'b1;
				if (clr_last)
					state_nxt = lphi_pkg::B_IDLE;
			end
			lphi_pkg::B_IDLE: begin
				// start only with room for the result already reserved
				if (job_valid && oq_cnt_q != 2'd2) begin
					job_pop   = 1'b1;
					state_nxt = lphi_pkg::B_FETCH;
				end
			end
			lphi_pkg::B_FETCH: begin
				mem_re    = 1'b1;
				state_nxt = lphi_pkg::B_TEST;
			end
			lphi_pkg::B_TEST: begin
				if (is_full) begin
					res_push  = 1'b1;
					state_nxt = lphi_pkg::B_IDLE;
				end else if (!cur_bit) begin
					ins       = 1'b1;
					mem_we    = 1'b1;
					mem_wa    = pos_q[SW-1:IW];
					mem_wd    = row_q | set_mask;
					res_push  = 1'b1;
					res_d     = '{slot: pos_q,
					              status: (passed_q == '0) ? lphi_pkg::STATUS_HOME
					                                       : lphi_pkg::STATUS_PROBED,
					              probes: passed_q,
					              occupancy: used_count_q + lphi_pkg::CNT_W'(1)};
					state_nxt = lphi_pkg::B_IDLE;
				end else begin
					step = 1'b1;
					// a new row needs a fresh read
					if (pos_nxt[SW-1:IW] != pos_q[SW-1:IW])
						state_nxt = lphi_pkg::B_FETCH;
				end
			end
			default: state_nxt = lphi_pkg::B_IDLE;
		endcase
	end

	// occupancy and value memories
	always_ff @(posedge clk) begin
		if (mem_we)
			used_mem[mem_wa] <= mem_wd;
		if (mem_re)
			row_q <= used_mem[mem_ra];
		if (ins)
			value_mem[pos_q] <= value_q;
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q    <= '0;
			used_count_q <= '0;
		end else begin
			if (clearing)
				clr_row_q <= clr_row_q + lphi_pkg::ROW_W'(1);
			if (ins)
				used_count_q <= used_count_q + lphi_pkg::CNT_W'(1);
		end
	end

	// probe walk registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			pos_q    <= job.home;
			passed_q <= '0;
			size_q   <= job.size;
			value_q  <= job.value;
		end else if (step) begin
			pos_q    <= pos_nxt;
			passed_q <= passed_q + lphi_pkg::CNT_W'(1);
		end
	end

	// two-word result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (res_push)
				oq_wr_q <= !oq_wr_q;
			if (pop && !empty)
				oq_rd_q <= !oq_rd_q;
			case ({res_push, pop && !empty})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			oq_mem_q[oq_wr_q] <= res_d;
	end

	assign empty  = (oq_cnt_q == 2'd0);
	assign result = oq_mem_q[oq_rd_q];

endmodule

[hw/rtl/linear_probe_hash_insert.sv]
`timescale 1ns / 1ps
// Linear-probing hash insert.
// Input queue side: key is taken when push is high and full is low.
// Result queue side: slot, status, probes and occupancy show the oldest result
// while empty is low; it leaves on a clock edge with pop high.
// status: home slot, stored after probing, or table full (slot 0, nothing changed).
// table_size sits at APB byte address 0; zero acts as one slot, values above
// the table depth act as the full depth. Write it only while the block is idle.
// Flow: after the accept cycle the front end runs the divider (four quotient
// bits per cycle), then hands the job into the job queue, which can stall
// while that queue is full; full stays high until the hand-off, so the input
// takes no new word while one is still in the front end. The probe engine
// takes the job, reads the occupancy row and tests the home slot, then tests
// one more slot for each occupied slot passed, with a fresh row read each time
// the walk enters a new 32-slot row (single read port). Front and back overlap
// through a two-word queue, so the front end can divide one word while the
// probe engine works on an earlier one.
// Reset: the occupancy memory is cleared row by row, all 512 rows, with full
// held high; the occupancy count starts at zero.
// A stalled result side fills the two-word result queue, then the job queue,
// then holds full high; no word is lost.

module linear_probe_hash_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lphi_pkg::VALUE_W-1:0]  key,
	output logic                          empty,
	input  logic                          pop,
	output logic [lphi_pkg::SLOT_W-1:0]   slot,
	output logic [1:0]                    status,
	output logic [lphi_pkg::CNT_W-1:0]    probes,
	output logic [lphi_pkg::CNT_W-1:0]    occupancy,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lphi_pkg::ADDR_W-1:0]   paddr,
	input  logic [lphi_pkg::DATA_W-1:0]   pwdata,
	output logic [lphi_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [lphi_pkg::SIZE_W-1:0] table_size_q;
	logic                        clearing, job_valid, job_pop, reg_hit;
	lphi_pkg::job_t              job;
	lphi_pkg::result_t           result;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[lphi_pkg::ADDR_W-1:2] == lphi_pkg::REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_size_q <= lphi_pkg::SIZE_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			table_size_q <= pwdata[lphi_pkg::SIZE_W-1:0];
	end

	assign prdata = reg_hit ? {{(lphi_pkg::DATA_W - lphi_pkg::SIZE_W){1'b0}}, table_size_q}
	                        : '0;

	lphi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.key        (key),
		.size       (lphi_pkg::eff_size(table_size_q)),
		.clearing   (clearing),
		.full       (full),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop)
	);

	lphi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	assign slot      = result.slot;
	assign status    = result.status;
	assign probes    = result.probes;
	assign occupancy = result.occupancy;

	// no word gets in while the occupancy memory is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("word accepted during clearing pass");

	// a full-table result reports slot 0 and a nonzero probe count
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == lphi_pkg::STATUS_FULL) |-> (slot == '0 && probes != '0))
		else $error("bad full-table result");

	// home status exactly when no occupied slot was passed
	a_home_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != lphi_pkg::STATUS_FULL)
			|-> ((probes == '0) == (status == lphi_pkg::STATUS_HOME)))
		else $error("status does not match probe count");

endmodule
